@@ rtl/core/wifi_module_frame_receiver_macros.svh @@
// Assertion macros shared by the frame receiver RTL.
// Uses i_clk and i_rst_n of the module that expands them; no other dependencies.
`ifndef WIFI_MODULE_FRAME_RECEIVER_MACROS_SVH
`define WIFI_MODULE_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked out of reset.
`define WMFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("wmfr assertion failed");
// Antecedent/consequent pair, consequent checked on the next edge.
`define WMFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmfr assertion failed");
`else
`define WMFR_ASSERT(lbl, prop)
`define WMFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/wmfr_pkg.sv @@
// Types and constants for the frame receiver.
// No dependencies; used by wmfr_core, wmfr_out_buf and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wmfr_pkg;

    localparam logic [7:0] DATA_START  = 8'hBB;
    localparam logic [7:0] HDR_A5      = 8'hA5;
    localparam logic [7:0] HDR_5A      = 8'h5A;
    localparam logic [7:0] DATA_TAIL   = 8'h44;
    localparam logic [7:0] CODE_RESET  = 8'hE9;
    localparam logic [7:0] CODE_STATUS = 8'hEC;
    localparam logic [7:0] CODE_TIME   = 8'hEE;

    localparam logic [5:0] POS_HDR_END    = 6'd3;
    localparam logic [5:0] POS_CODE       = 6'd6;
    localparam logic [5:0] POS_RESET_END  = 6'd11;
    localparam logic [5:0] POS_STATUS     = 6'd12;
    localparam logic [5:0] POS_STATUS_END = 6'd15;
    localparam logic [5:0] POS_TIME_END   = 6'd19;
    localparam logic [5:0] POS_CHECK      = 6'd61;
    localparam logic [5:0] POS_TAIL       = 6'd62;

    typedef enum logic [2:0] {
        MODE_HUNT = 3'b001,
        MODE_CMD  = 3'b010,
        MODE_DATA = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        EV_HUNT   = 3'd0,
        EV_FRAME  = 3'd1,
        EV_RESET  = 3'd2,
        EV_STATUS = 3'd3,
        EV_TIME   = 3'd4,
        EV_DROP   = 3'd5,
        EV_OK     = 3'd6,
        EV_BAD    = 3'd7
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [5:0] frame_pos;
        logic [7:0] byte_value;
        logic [7:0] module_status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/wmfr_core.sv @@
// Frame parser: mode, position, header window, code/status and checksum state.
// Depends on wmfr_pkg; one byte per i_go, result formed combinationally.
`timescale 1ns / 1ps
`default_nettype none
`include "wifi_module_frame_receiver_macros.svh"

module wmfr_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [7:0]       i_byte,
    output wmfr_pkg::t_result     o_result
);
    import wmfr_pkg::*;

    t_mode            r_mode,   n_mode;
    logic [5:0]       r_pos,    n_pos;
    logic [3:0][7:0]  r_win,    n_win;
    logic [7:0]       r_code,   n_code;
    logic [7:0]       r_status, n_status;
    logic [7:0]       r_sum,    n_sum;
    logic [7:0]       r_check,  n_check;
    logic [5:0]       p_inc;
    t_result          res;

    assign p_inc = r_pos + 6'd1;

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_win    = r_win;
        n_code   = r_code;
        n_status = r_status;
        n_sum    = r_sum;
        n_check  = r_check;
        res.event_res     = EV_HUNT;
        res.frame_pos     = 6'd0;
        res.byte_value    = i_byte;
        res.module_status = 8'd0;
        unique case (r_mode)
            MODE_CMD: begin
                n_pos = p_inc;
                res.frame_pos = p_inc;
                res.event_res = EV_FRAME;
                if (p_inc == POS_CODE) n_code = i_byte;
                if (p_inc == POS_STATUS) n_status = i_byte;
                if (p_inc == POS_RESET_END && r_code == CODE_RESET) begin
                    res.event_res = EV_RESET;
                    n_mode = MODE_HUNT;
                end else if (p_inc == POS_STATUS_END && r_code == CODE_STATUS) begin
                    res.event_res = EV_STATUS;
                    res.module_status = r_status;
                    n_mode = MODE_HUNT;
                end else if (p_inc == POS_TIME_END && r_code == CODE_TIME) begin
                    res.event_res = EV_TIME;
                    n_mode = MODE_HUNT;
                end else if (p_inc > POS_TIME_END) begin
                    res.event_res = EV_DROP;
                    n_mode = MODE_HUNT;
                end
            end
            MODE_DATA: begin
                n_pos = p_inc;
                res.frame_pos = p_inc;
                res.event_res = EV_FRAME;
                if (p_inc[5:2] == 4'd0) n_win[p_inc[1:0]] = i_byte;
                if (p_inc == POS_CHECK) n_check = i_byte;
                if (p_inc < POS_CHECK) begin
                    n_sum = r_sum + i_byte;
                end else if (p_inc == POS_TAIL && i_byte == DATA_TAIL
                             && r_check == 8'(~r_sum + 8'd1)) begin
                    res.event_res = EV_OK;
                    n_mode = MODE_HUNT;
                end else if (p_inc > POS_TAIL) begin
                    res.event_res = EV_BAD;
                    n_mode = MODE_HUNT;
                end
            end
            default: begin
                if (i_byte == DATA_START) begin
                    n_win[0] = DATA_START;
                    n_pos    = 6'd0;
                    n_sum    = 8'd0;
                    n_mode   = MODE_DATA;
                    res.event_res = EV_FRAME;
                end else begin
                    n_win = {i_byte, r_win[3], r_win[2], r_win[1]};
                    if (r_win[1] == HDR_A5 && r_win[2] == HDR_A5
                        && r_win[3] == HDR_5A && i_byte == HDR_5A) begin
                        n_pos  = POS_HDR_END;
                        n_mode = MODE_CMD;
                        res.event_res = EV_FRAME;
                        res.frame_pos = POS_HDR_END;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HUNT;
            r_pos    <= 6'd0;
            r_win    <= '0;
            r_code   <= 8'd0;
            r_status <= 8'd0;
            r_sum    <= 8'd0;
            r_check  <= 8'd0;
        end else if (i_go) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_win    <= n_win;
            r_code   <= n_code;
            r_status <= n_status;
            r_sum    <= n_sum;
            r_check  <= n_check;
        end
    end

    assign o_result = res;

    `WMFR_ASSERT(a_cmd_pos_range, (r_mode != MODE_CMD) || (r_pos >= POS_HDR_END && r_pos <= POS_TIME_END))
    `WMFR_ASSERT(a_data_pos_range, (r_mode != MODE_DATA) || (r_pos <= POS_CHECK) || (r_pos == POS_TAIL))
    `WMFR_ASSERT(a_status_code, !(i_go && res.event_res == EV_STATUS) || (r_code == CODE_STATUS))

endmodule

`default_nettype wire

@@ rtl/core/wmfr_out_buf.sv @@
// Two-entry result buffer between the parser and the output channel.
// Depends on wmfr_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none
`include "wifi_module_frame_receiver_macros.svh"

module wmfr_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wmfr_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output wmfr_pkg::t_result     o_data
);
    import wmfr_pkg::*;

    t_result     r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            if (i_push && !pop) r_cnt <= r_cnt + 2'd1;
            else if (pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    `WMFR_ASSERT(a_cnt_range, r_cnt != 2'd3)
    `WMFR_ASSERT(a_no_push_full, !(i_push && o_full))
    `WMFR_ASSERT_NEXT(a_pop_drains, pop && !i_push, r_cnt == $past(r_cnt) - 2'd1)

endmodule

`default_nettype wire

@@ rtl/core/wifi_module_frame_receiver.sv @@
// Frame receiver top level: input beat register, parser and result buffer.
// Depends on wmfr_pkg, wmfr_core and wmfr_out_buf.
//
// Usage:
//   Input channel (i_rx_valid / o_rx_stall) carries one received byte per beat.
//   Output channel (o_res_valid / i_res_stall) carries one result beat per
//   input beat, in order: event code, frame position, echoed byte, status.
//   A byte accepted on the input passes through the input register, then is
//   parsed into the result buffer that drives the output channel.
//   Throughput: one byte per cycle while the result buffer is not full; the
//   parser state is updated from the registered byte as it advances.
//   The result buffer holds two beats, so a new byte is still taken while a
//   result waits. o_rx_stall rises only when the input register is occupied
//   and both buffer entries are full; it is driven from registers only.
//   Reset (synchronous, active low) empties the pipeline and returns the
//   parser to hunting with a cleared header window and checksum state.
`timescale 1ns / 1ps
`default_nettype none

module wifi_module_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [2:0]       o_event_res,
    output logic [5:0]       o_frame_pos,
    output logic [7:0]       o_byte_value,
    output logic [7:0]       o_module_status
);
    import wmfr_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        buf_full;
    logic        advance;
    logic        accept;
    t_result     core_res;
    t_result     out_res;

    assign advance    = r_in_valid && !buf_full;
    assign o_rx_stall = r_in_valid && buf_full;
    assign accept     = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in_byte <= i_rx_byte;
    end

    wmfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (advance),
        .i_byte   (r_in_byte),
        .o_result (core_res)
    );

    wmfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (core_res),
        .o_full  (buf_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_data  (out_res)
    );

    assign o_event_res     = out_res.event_res;
    assign o_frame_pos     = out_res.frame_pos;
    assign o_byte_value    = out_res.byte_value;
    assign o_module_status = out_res.module_status;

endmodule

`default_nettype wire
